// ===== sv/nfam_pkg.sv =====
// shared types and constants for the nfa symbol matcher
package nfam_pkg;

    // fixed field widths of the transaction payload
    localparam int STATE_IDX_W = 4;
    localparam int SYMBOL_W    = 8;
    localparam int START_W     = 4;
    localparam int ACCEPT_W    = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 4'd1;

    // input action codes
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_BEGIN = 2'd2,
        ACT_BYTE  = 2'd3
    } action_t;

    // transition write broadcast to the cell row
    typedef struct packed {
        logic [STATE_IDX_W-1:0] src;
        logic [STATE_IDX_W-1:0] dst;
        logic [SYMBOL_W-1:0]    label;
        logic                   eps;
    } entry_wr_t;

    // per-pass control broadcast to the cell row
    typedef struct packed {
        logic                eps_pass;
        logic [SYMBOL_W-1:0] text_byte;
    } pass_ctl_t;

endpackage

// ===== sv/nfam_cell.sv =====
// one transition cell: holds an entry and ors its move into the chain
module nfam_cell #(
    parameter int NUM_STATES = 16
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  nfam_pkg::entry_wr_t     wr,
    input  logic                    live,
    input  nfam_pkg::pass_ctl_t     ctl,
    input  logic [NUM_STATES-1:0]   set_in,
    input  logic [NUM_STATES-1:0]   acc_in,
    output logic [NUM_STATES-1:0]   acc_out
);

    logic [NUM_STATES-1:0]         src_oh_reg;
    logic [NUM_STATES-1:0]         dst_oh_reg;
    logic [nfam_pkg::SYMBOL_W-1:0] label_reg;
    logic                          eps_reg;
    logic [NUM_STATES-1:0]         src_oh_next;
    logic [NUM_STATES-1:0]         dst_oh_next;
    logic                          fire;

    // decode state indexes once at write time; out-of-range states decode to zero
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            src_oh_next[i] = (32'(wr.src) == i);
            dst_oh_next[i] = (32'(wr.dst) == i);
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            src_oh_reg <= src_oh_next;
            dst_oh_reg <= dst_oh_next;
            label_reg  <= wr.label;
            eps_reg    <= wr.eps;
        end
    end

    // match against the current pass and pass the accumulated set on
    always_comb begin
        if (ctl.eps_pass) begin
            fire = live && eps_reg && (|(set_in & src_oh_reg));
        end else begin
            fire = live && !eps_reg && (label_reg == ctl.text_byte) &&
                   (|(set_in & src_oh_reg));
        end
        acc_out = fire ? (acc_in | dst_oh_reg) : acc_in;
    end

endmodule

// ===== sv/nfa_symbol_matcher_core.sv =====
// nfa symbol matcher top level: transaction control, active set and cell row
// sequence: an add goes straight to emit; a begin loads the start state, a text byte first
// takes a labelled move pass, then both run epsilon closure passes, one per cycle, until
// nothing new is reached, going to emit only with last set; clear stays in idle; new input
// is taken only in idle; a result still waiting in the output register holds the block in emit
// reset clears config, active set, entry count and handshake state; entries undefined until written
module nfa_symbol_matcher_core #(
    parameter int NUM_STATES      = 16,
    parameter int MAX_TRANSITIONS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nfam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nfam_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic [nfam_pkg::STATE_IDX_W-1:0]  s_source_state,
    input  logic [nfam_pkg::STATE_IDX_W-1:0]  s_dest_state,
    input  logic [nfam_pkg::SYMBOL_W-1:0]     s_symbol,
    input  logic                              s_is_epsilon,
    input  logic                              s_last,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic                              m_accepted,
    output logic                              m_write_ok
);

    localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);
    localparam int AM_W  = (NUM_STATES < nfam_pkg::ACCEPT_W) ? NUM_STATES : nfam_pkg::ACCEPT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MOVE  = 4'b0010,
        ST_CLOSE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                                state_reg, state_next;
    logic [nfam_pkg::START_W-1:0]          start_state_reg, start_state_next;
    logic [nfam_pkg::ACCEPT_W-1:0]         accept_mask_reg, accept_mask_next;
    logic [NUM_STATES-1:0]                 set_reg, set_next;
    logic [CNT_W-1:0]                      count_reg, count_next;
    logic [nfam_pkg::SYMBOL_W-1:0]         byte_reg, byte_next;
    logic                                  last_reg, last_next;
    logic                                  res_kind_reg, res_kind_next;
    logic                                  res_acc_reg, res_acc_next;
    logic                                  res_ok_reg, res_ok_next;
    logic                                  m_valid_reg, m_valid_next;
    logic                                  m_kind_reg, m_kind_next;
    logic                                  m_accepted_reg, m_accepted_next;
    logic                                  m_write_ok_reg, m_write_ok_next;

    nfam_pkg::action_t                     action;
    nfam_pkg::entry_wr_t                   wr;
    nfam_pkg::pass_ctl_t                   ctl;
    logic                                  s_fire;
    logic                                  add_fire;
    logic                                  table_full;
    logic                                  slot_free;
    logic [NUM_STATES-1:0]                 start_oh;
    logic [NUM_STATES-1:0]                 accept_ext;
    logic [NUM_STATES-1:0]                 chain_in;
    logic [NUM_STATES-1:0]                 chain_out;
    logic [NUM_STATES-1:0]                 acc [MAX_TRANSITIONS+1];

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign action     = nfam_pkg::action_t'(s_action);
    assign table_full = !(32'(count_reg) < MAX_TRANSITIONS);
    assign add_fire   = s_fire && (action == nfam_pkg::ACT_ADD) && !table_full;
    assign slot_free  = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_accepted = m_accepted_reg;
    assign m_write_ok = m_write_ok_reg;

    // start state decode and accept mask fitted to the state count
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            start_oh[i] = (32'(start_state_reg) == i);
        end
        accept_ext             = '0;
        accept_ext[AM_W-1:0]   = accept_mask_reg[AM_W-1:0];
    end

    // broadcast to the cell row
    assign wr.src        = s_source_state;
    assign wr.dst        = s_dest_state;
    assign wr.label      = s_symbol;
    assign wr.eps        = s_is_epsilon;
    assign ctl.eps_pass  = (state_reg == ST_CLOSE);
    assign ctl.text_byte = byte_reg;
    assign chain_in      = (state_reg == ST_CLOSE) ? set_reg : '0;

    // row of transition cells, the accumulated set ripples from cell to cell
    assign acc[0] = chain_in;
    for (genvar k = 0; k < MAX_TRANSITIONS; k++) begin : g_cell
        nfam_cell #(
            .NUM_STATES (NUM_STATES)
        ) u_cell (
            .aclk    (aclk),
            .wr_en   (add_fire && (32'(count_reg) == k)),
            .wr      (wr),
            .live    (32'(count_reg) > k),
            .ctl     (ctl),
            .set_in  (set_reg),
            .acc_in  (acc[k]),
            .acc_out (acc[k+1])
        );
    end
    assign chain_out = acc[MAX_TRANSITIONS];

    // configuration writes
    always_comb begin
        start_state_next = start_state_reg;
        accept_mask_next = accept_mask_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                nfam_pkg::CFG_START_STATE: start_state_next = cfg_data[nfam_pkg::START_W-1:0];
                nfam_pkg::CFG_ACCEPT_MASK: accept_mask_next = cfg_data;
                default: ;
            endcase
        end
    end

    // transaction sequencing
    always_comb begin
        state_next    = state_reg;
        set_next      = set_reg;
        count_next    = count_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        res_kind_next = res_kind_reg;
        res_acc_next  = res_acc_reg;
        res_ok_next   = res_ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    byte_next = s_symbol;
                    last_next = s_last;
                    case (action)
                        nfam_pkg::ACT_ADD: begin
                            if (!table_full) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            res_kind_next = 1'b1;
                            res_acc_next  = 1'b0;
                            res_ok_next   = !table_full;
                            state_next    = ST_EMIT;
                        end
                        nfam_pkg::ACT_CLEAR: begin
                            count_next = '0;
                        end
                        nfam_pkg::ACT_BEGIN: begin
                            set_next   = start_oh;
                            state_next = ST_CLOSE;
                        end
                        default: begin
                            state_next = ST_MOVE;
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                set_next   = chain_out;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                // one epsilon pass per cycle until nothing new is reached
                if (chain_out == set_reg) begin
                    res_kind_next = 1'b0;
                    res_acc_next  = |(set_reg & accept_ext);
                    res_ok_next   = 1'b0;
                    state_next    = last_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    set_next = chain_out;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_accepted_next = m_accepted_reg;
        m_write_ok_next = m_write_ok_reg;
        if ((state_reg == ST_EMIT) && slot_free) begin
            m_valid_next    = 1'b1;
            m_kind_next     = res_kind_reg;
            m_accepted_next = res_acc_reg;
            m_write_ok_next = res_ok_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            start_state_reg <= '0;
            accept_mask_reg <= '0;
            set_reg         <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            start_state_reg <= start_state_next;
            accept_mask_reg <= accept_mask_next;
            set_reg         <= set_next;
            count_reg       <= count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        res_kind_reg   <= res_kind_next;
        res_acc_reg    <= res_acc_next;
        res_ok_reg     <= res_ok_next;
        m_kind_reg     <= m_kind_next;
        m_accepted_reg <= m_accepted_next;
        m_write_ok_reg <= m_write_ok_next;
    end

    // entry count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_TRANSITIONS)
        else $error("entry count beyond table size");

    // an epsilon pass never drops an active state
    a_close_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE) |=> ((set_reg & $past(set_reg)) == $past(set_reg)))
        else $error("closure pass lost an active state");

    // an acknowledgement never carries a verdict, a verdict never a write status
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind ? !m_accepted : !m_write_ok))
        else $error("result fields inconsistent with kind");

endmodule

// ===== bench/nfa_symbol_matcher_core_test.sv =====
// self-checking testbench for the nfa symbol matcher core
module nfa_symbol_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STATES      = 16;
    localparam int MAX_TRANSITIONS = 64;
    localparam int RANDOM_ITEMS    = 1600;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PRINT_LIMIT     = 50;

    // register indexes that map to no register
    localparam logic [nfam_pkg::CFG_IDX_W-1:0] CFG_NO_REG_LOW  = 4'h2;
    localparam logic [nfam_pkg::CFG_IDX_W-1:0] CFG_NO_REG_HIGH = 4'hF;

    // one input transaction
    typedef struct {
        nfam_pkg::action_t                act;
        logic [nfam_pkg::STATE_IDX_W-1:0] src;
        logic [nfam_pkg::STATE_IDX_W-1:0] dst;
        logic [nfam_pkg::SYMBOL_W-1:0]    sym;
        logic                             eps;
        logic                             last;
    } nfa_item_t;

    // one result transaction
    typedef struct packed {
        logic kind;
        logic accepted;
        logic write_ok;
    } nfa_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [nfam_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [nfam_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [1:0]                       s_action;
    logic [nfam_pkg::STATE_IDX_W-1:0] s_source_state;
    logic [nfam_pkg::STATE_IDX_W-1:0] s_dest_state;
    logic [nfam_pkg::SYMBOL_W-1:0]    s_symbol;
    logic                             s_is_epsilon;
    logic                             s_last;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_kind;
    logic                             m_accepted;
    logic                             m_write_ok;

    nfa_symbol_matcher_core #(
        .NUM_STATES      (NUM_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_source_state (s_source_state),
        .s_dest_state   (s_dest_state),
        .s_symbol       (s_symbol),
        .s_is_epsilon   (s_is_epsilon),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_accepted     (m_accepted),
        .m_write_ok     (m_write_ok)
    );

    always #6 aclk = ~aclk;

    // automaton shadow state
    logic [nfam_pkg::START_W-1:0]     start_reg  = '0;
    logic [nfam_pkg::ACCEPT_W-1:0]    accept_reg = '0;
    logic [NUM_STATES-1:0]            active_set = '0;
    logic [nfam_pkg::STATE_IDX_W-1:0] edge_src [MAX_TRANSITIONS];
    logic [nfam_pkg::STATE_IDX_W-1:0] edge_dst [MAX_TRANSITIONS];
    logic [nfam_pkg::SYMBOL_W-1:0]    edge_label [MAX_TRANSITIONS];
    logic                             edge_eps [MAX_TRANSITIONS];
    int                               edge_count = 0;

    nfa_result_t pending_results [$];

    // bookkeeping
    int  n_errors   = 0;
    int  n_items    = 0;
    int  n_acks     = 0;
    int  n_refused  = 0;
    int  n_verdicts = 0;
    int  n_hits     = 0;
    int  n_cfg      = 0;
    int  burst_left = 0;
    bit  hold_req   = 1'b0;
    int  quiet_cycles = 0;

    task automatic report_mismatch(string what, int got, int want);
        if (n_errors < PRINT_LIMIT)
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // close a state set under epsilon moves
    function automatic logic [NUM_STATES-1:0] eps_closure(logic [NUM_STATES-1:0] set);
        logic [NUM_STATES-1:0] grown;
        for (int pass = 0; pass < NUM_STATES; pass++) begin
            grown = set;
            for (int k = 0; k < edge_count; k++)
                if (edge_eps[k] && set[edge_src[k]])
                    grown[edge_dst[k]] = 1'b1;
            set = grown;
        end
        return set;
    endfunction

    // move every active state along the labelled transitions
    function automatic logic [NUM_STATES-1:0] byte_step(logic [NUM_STATES-1:0] set,
                                                        logic [nfam_pkg::SYMBOL_W-1:0] text_byte);
        logic [NUM_STATES-1:0] next;
        next = '0;
        for (int k = 0; k < edge_count; k++)
            if (!edge_eps[k] && edge_label[k] == text_byte && set[edge_src[k]])
                next[edge_dst[k]] = 1'b1;
        return next;
    endfunction

    // update shadow state for one accepted transaction and queue its result
    task automatic predict_item(nfa_item_t it);
        nfa_result_t r;
        r = '0;
        case (it.act)
            nfam_pkg::ACT_ADD: begin
                r.kind = 1'b1;
                if (edge_count < MAX_TRANSITIONS) begin
                    edge_src[edge_count]   = it.src;
                    edge_dst[edge_count]   = it.dst;
                    edge_label[edge_count] = it.sym;
                    edge_eps[edge_count]   = it.eps;
                    edge_count++;
                    r.write_ok = 1'b1;
                end else begin
                    n_refused++;
                end
                n_acks++;
                pending_results.push_back(r);
            end
            nfam_pkg::ACT_CLEAR: begin
                edge_count = 0;
            end
            default: begin
                if (it.act == nfam_pkg::ACT_BEGIN)
                    active_set = eps_closure(NUM_STATES'(1) << start_reg);
                else
                    active_set = eps_closure(byte_step(active_set, it.sym));
                if (it.last) begin
                    r.accepted = |(active_set & accept_reg[NUM_STATES-1:0]);
                    n_verdicts++;
                    if (r.accepted)
                        n_hits++;
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    function automatic nfa_item_t make_item(nfam_pkg::action_t act, int src, int dst, int sym,
                                            bit eps, bit last);
        nfa_item_t it;
        it.act  = act;
        it.src  = src[nfam_pkg::STATE_IDX_W-1:0];
        it.dst  = dst[nfam_pkg::STATE_IDX_W-1:0];
        it.sym  = sym[nfam_pkg::SYMBOL_W-1:0];
        it.eps  = eps;
        it.last = last;
        return it;
    endfunction

    function automatic nfa_item_t noise_item();
        return make_item(nfam_pkg::action_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 255),
                         $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // send one transaction, bursts separated by random gaps; called at a falling edge
    task automatic send_item(nfa_item_t it);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_action       = it.act;
        s_source_state = it.src;
        s_dest_state   = it.dst;
        s_symbol       = it.sym;
        s_is_epsilon   = it.eps;
        s_last         = it.last;
        s_valid        = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(it);
        n_items++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(logic [nfam_pkg::CFG_IDX_W-1:0] idx,
                             logic [nfam_pkg::CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == nfam_pkg::CFG_START_STATE)
            start_reg = data[nfam_pkg::START_W-1:0];
        else if (idx == nfam_pkg::CFG_ACCEPT_MASK)
            accept_reg = data[nfam_pkg::ACCEPT_W-1:0];
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // wait for every pending result, then let any silent transaction finish
    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // bytes before any begin, and an empty string, on reset defaults
    task automatic test_after_reset();
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h61, 1'b0, 1'b1));
        send_item(make_item(nfam_pkg::ACT_BEGIN, 15, 15, 8'hFF, 1'b1, 1'b1));
        wait_drained();
    endtask

    // hand-built automaton: an epsilon move, labelled epsilons, extreme states and bytes
    task automatic test_directed_paths();
        write_reg(nfam_pkg::CFG_START_STATE, 16'hFFF1);
        write_reg(nfam_pkg::CFG_ACCEPT_MASK, 16'h8020);
        write_reg(CFG_NO_REG_HIGH, 16'hFFFF);
        write_reg(CFG_NO_REG_LOW, 16'h0000);
        send_item(make_item(nfam_pkg::ACT_CLEAR, 0, 0, 0, 1'b0, 1'b1));
        // add with last set still gives only an acknowledgement
        send_item(make_item(nfam_pkg::ACT_ADD, 1, 2, 8'h61, 1'b0, 1'b1));
        // epsilon move whose label must never match a byte
        send_item(make_item(nfam_pkg::ACT_ADD, 2, 5, 8'h62, 1'b1, 1'b0));
        send_item(make_item(nfam_pkg::ACT_ADD, 0, 15, 8'h00, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_ADD, 15, 0, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h61, 1'b0, 1'b1));
        send_item(make_item(nfam_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h61, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h62, 1'b0, 1'b1));
        send_item(make_item(nfam_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, 1'b1));
        wait_drained();
        write_reg(nfam_pkg::CFG_START_STATE, 16'h0000);
        send_item(make_item(nfam_pkg::ACT_BEGIN, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h00, 1'b0, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'hFF, 1'b0, 1'b1));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'h00, 1'b0, 1'b1));
        // clear keeps the active set, but no transition remains to follow
        send_item(make_item(nfam_pkg::ACT_CLEAR, 15, 15, 8'hFF, 1'b1, 1'b0));
        send_item(make_item(nfam_pkg::ACT_BYTE, 0, 0, 8'hFF, 1'b0, 1'b1));
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering adds
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        send_item(make_item(nfam_pkg::ACT_CLEAR, 0, 0, 0, 1'b0, 1'b0));
        for (int i = 0; i < 12; i++)
            send_item(make_item(nfam_pkg::ACT_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 255), $urandom_range(0, 1), 1'b0));
        wait_drained();
        hold_req = 1'b0;
    endtask

    // phases of config, table load and strings, with noise and broken sequences
    task automatic test_random_traffic();
        int          target;
        int          phase;
        int          states_used;
        int          n_add;
        int          n_str;
        int          len;
        int          pick;
        logic [7:0]  alpha;
        logic [15:0] mask;
        bit          eps;
        target = n_items + RANDOM_ITEMS;
        phase  = 0;
        while (n_items < target) begin
            states_used = $urandom_range(2, 16);
            alpha       = $urandom_range(0, 252);
            mask        = (states_used == 16) ? 16'hFFFF : (16'(1) << states_used) - 16'd1;
            // new settings only while idle
            if (phase == 0 || $urandom_range(0, 3) == 0) begin
                wait_drained();
                pick = $urandom_range(0, 5);
                write_reg(nfam_pkg::CFG_START_STATE, {12'($urandom), 4'(pick == 0 ? 15 :
                          pick == 1 ? 0 : $urandom_range(0, states_used - 1))});
                write_reg(nfam_pkg::CFG_ACCEPT_MASK, pick == 2 ? 16'h0000 :
                          pick == 3 ? 16'hFFFF :
                          pick == 4 ? 16'($urandom) : 16'($urandom) & mask);
                if ($urandom_range(0, 7) == 0)
                    write_reg(4'($urandom_range(CFG_NO_REG_LOW, CFG_NO_REG_HIGH)),
                              16'($urandom));
            end
            if ($urandom_range(0, 2) != 0)
                send_item(make_item(nfam_pkg::ACT_CLEAR, $urandom_range(0, 15),
                                    $urandom_range(0, 15),
                                    $urandom_range(0, 255), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
            // occasionally overfill the table
            n_add = (phase == 0 || $urandom_range(0, 15) == 0) ? $urandom_range(60, 72)
                                                                : $urandom_range(1, 12);
            for (int i = 0; i < n_add; i++) begin
                eps = ($urandom_range(0, 3) == 0);
                send_item(make_item(nfam_pkg::ACT_ADD, $urandom_range(0, states_used - 1),
                                    $urandom_range(0, states_used - 1),
                                    eps ? $urandom_range(0, 255) : alpha + $urandom_range(0, 3),
                                    eps, $urandom_range(0, 1)));
            end
            n_str = $urandom_range(2, 8);
            for (int s = 0; s < n_str; s++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // empty string
                    send_item(make_item(nfam_pkg::ACT_BEGIN, $urandom_range(0, 15),
                                        $urandom_range(0, 15),
                                        $urandom_range(0, 255), $urandom_range(0, 1), 1'b1));
                end else begin
                    send_item(make_item(nfam_pkg::ACT_BEGIN, $urandom_range(0, 15),
                                        $urandom_range(0, 15),
                                        $urandom_range(0, 255), $urandom_range(0, 1), 1'b0));
                    len = $urandom_range(1, 8);
                    for (int b = 0; b < len; b++)
                        send_item(make_item(nfam_pkg::ACT_BYTE, $urandom_range(0, 15),
                                            $urandom_range(0, 15),
                                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                        : alpha + $urandom_range(0, 3),
                                            $urandom_range(0, 1), b == len - 1));
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_item(noise_item());
            end
            phase++;
        end
        wait_drained();
    endtask

    // result checker and receiver stall pattern
    task automatic check_result();
        nfa_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, kind", m_kind, -1);
        end else begin
            want = pending_results.pop_front();
            if (m_kind !== want.kind)
                report_mismatch("kind", m_kind, want.kind);
            if (m_accepted !== want.accepted)
                report_mismatch("accepted", m_accepted, want.accepted);
            if (m_write_ok !== want.write_ok)
                report_mismatch("write_ok", m_write_ok, want.write_ok);
        end
    endtask

    initial begin
        int ready_mode;
        int mode_left;
        int beat;
        int hold_count;
        bit hold_done;
        ready_mode = 0;
        mode_left  = 0;
        beat       = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                check_result();
            @(negedge aclk);
            // long hold-off so the block fills and stalls its input
            if (hold_req && !hold_done) begin
                m_ready    = 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_count++;
                end
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;
            beat++;
            case (ready_mode)
                0:       m_ready = 1'b1;
                1:       m_ready = ($urandom_range(0, 3) != 0);
                2:       m_ready = (beat % 7) >= 2;
                default: m_ready = ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // test sequence
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_action       = nfam_pkg::ACT_ADD;
        s_source_state = '0;
        s_dest_state   = '0;
        s_symbol       = '0;
        s_is_epsilon   = 1'b0;
        s_last         = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        test_after_reset();
        test_directed_paths();
        test_output_backpressure();
        test_random_traffic();

        $display("covered %0d transactions and %0d register writes", n_items, n_cfg);
        $display("results: %0d acks (%0d refused on a full table), %0d verdicts (%0d accepting)",
                 n_acks, n_refused, n_verdicts, n_hits);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nfam_pkg.sv
sv/nfam_cell.sv
sv/nfa_symbol_matcher_core.sv
bench/nfa_symbol_matcher_core_test.sv
